// ----- hdl/ggr_pkg.sv -----
// ----------------------------------------------------------------------------
// ggr_pkg
// Shared constants, codes and controller/datapath signal groups of the
// greedy geometric router.
// ----------------------------------------------------------------------------
package ggr_pkg;

  localparam int MAX_NODES  = 256;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = NODE_W + 1;
  localparam int ANGLE_BITS = 16;
  localparam int LINK_DEPTH = MAX_NODES * MAX_NODES;
  localparam int LINK_AW    = 2 * NODE_W;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int HOP_W      = 8;

  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(MAX_NODES);

  // item commands
  localparam logic [CMD_W-1:0] CMD_ANGLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ROUTE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REACHED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FAIL    = 2'd2;

  typedef struct packed {
    logic                sweep_all;
    logic                sweep_vis;
    logic                wr_angle;
    logic                wr_link_ab;
    logic                wr_link_ba;
    logic                route_init;
    logic                tgt_latch;
    logic                scan_start;
    logic                scan_issue;
    logic                visit_write;
    logic                set_res;
    logic [STATUS_W-1:0] res_code;
    logic                res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             sweep_all_last;
    logic             sweep_vis_last;
    logic             at_target;
    logic             scan_done;
    logic             found;
    logic             visited_hit;
    logic             out_free;
  } dp_status_t;

endpackage

// ----- hdl/ggr_if.sv -----
// ----------------------------------------------------------------------------
// ggr channel interfaces
// Valid/ready channels for command words, result words and the node count
// register write.
// ----------------------------------------------------------------------------
interface ggr_item_if;
  import ggr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [NODE_W-1:0]     node_a;
  logic [NODE_W-1:0]     node_b;
  logic [ANGLE_BITS-1:0] angle;
  logic                  edge_present;

  modport source (output valid, command, node_a, node_b, angle, edge_present,
                  input ready);
  modport sink   (input valid, command, node_a, node_b, angle, edge_present,
                  output ready);
endinterface

interface ggr_result_if;
  import ggr_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HOP_W-1:0]    hop_count;

  modport source (output valid, status, hop_count, input ready);
  modport sink   (input valid, status, hop_count, output ready);
endinterface

interface ggr_cfg_if;
  import ggr_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] node_count;

  modport source (output valid, node_count, input ready);
  modport sink   (input valid, node_count, output ready);
endinterface

// ----- hdl/ggr_ram.sv -----
// ----------------------------------------------------------------------------
// ggr_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ggr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/ggr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ggr_ctrl
// Sequencer: memory clear after reset, write commands, and the greedy route
// loop (visited clear, neighbor scan, visited check, hop).
// ----------------------------------------------------------------------------
module ggr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_accept_i,
  input  ggr_pkg::dp_status_t sts_i,
  output ggr_pkg::ctrl_cmd_t  cmd_o,
  output logic                in_ready_o
);
  import ggr_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_EDGE2 = 4'd3;
  localparam logic [3:0] S_CLRV  = 4'd4;
  localparam logic [3:0] S_INIT  = 4'd5;
  localparam logic [3:0] S_TGT   = 4'd6;
  localparam logic [3:0] S_CHECK = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_VIS   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.sweep_all = 1'b1;
        if (sts_i.sweep_all_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.cmd)
          CMD_ANGLE: begin
            cmd_o.wr_angle = 1'b1;
            state_d        = S_DONE;
          end
          CMD_EDGE: begin
            cmd_o.wr_link_ab = 1'b1;
            state_d          = S_EDGE2;
          end
          CMD_ROUTE: begin
            state_d = S_CLRV;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_EDGE2: begin
        cmd_o.wr_link_ba = 1'b1;
        state_d          = S_DONE;
      end
      S_CLRV: begin
        cmd_o.sweep_vis = 1'b1;
        if (sts_i.sweep_vis_last) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.route_init = 1'b1;
        state_d          = S_TGT;
      end
      S_TGT: begin
        cmd_o.tgt_latch = 1'b1;
        state_d         = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.at_target) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_REACHED;
          state_d        = S_DONE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.found) begin
            state_d = S_VIS;
          end else begin
            // dead end: the current node has no linked neighbor
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = ST_FAIL;
            state_d        = S_DONE;
          end
        end
      end
      S_VIS: begin
        if (sts_i.visited_hit) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_FAIL;
          state_d        = S_DONE;
        end else begin
          cmd_o.visit_write = 1'b1;
          state_d           = S_CHECK;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/ggr_datapath.sv -----
// ----------------------------------------------------------------------------
// ggr_datapath
// Link, angle and visited memories, item and route registers, the scan
// pipeline with circular distance compare, and the result register.
// ----------------------------------------------------------------------------
module ggr_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_accept_i,
  input  logic [ggr_pkg::CMD_W-1:0]        in_command_i,
  input  logic [ggr_pkg::NODE_W-1:0]       in_node_a_i,
  input  logic [ggr_pkg::NODE_W-1:0]       in_node_b_i,
  input  logic [ggr_pkg::ANGLE_BITS-1:0]   in_angle_i,
  input  logic                             in_edge_present_i,
  input  logic                             cfg_we_i,
  input  logic [ggr_pkg::CNT_W-1:0]        cfg_node_count_i,
  input  ggr_pkg::ctrl_cmd_t               cmd_i,
  output ggr_pkg::dp_status_t              sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ggr_pkg::STATUS_W-1:0]     out_status_o,
  output logic [ggr_pkg::HOP_W-1:0]        out_hop_count_o
);
  import ggr_pkg::*;

  // item word
  logic [CMD_W-1:0]      cmd_q;
  logic [NODE_W-1:0]     a_q, b_q;
  logic [ANGLE_BITS-1:0] ang_q;
  logic                  present_q;

  logic [CNT_W-1:0]      node_count_q;
  logic [LINK_AW-1:0]    clr_cnt_q, clr_cnt_d;

  // route state
  logic [NODE_W-1:0]     cur_q;
  logic [HOP_W-1:0]      hops_q;
  logic [ANGLE_BITS-1:0] tgt_ang_q;
  logic [CNT_W-1:0]      scan_q;
  logic                  pend_q;
  logic [NODE_W-1:0]     pend_idx_q;
  logic [NODE_W-1:0]     best_q;
  logic [ANGLE_BITS-1:0] best_d_q;
  logic                  found_q;
  logic [STATUS_W-1:0]   res_q;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [HOP_W-1:0]      out_hop_q;

  logic [CNT_W-1:0]      n_eff;
  logic                  sweeping;
  logic                  scan_go;

  logic                  link_we, link_wdata, link_rd;
  logic [LINK_AW-1:0]    link_waddr, link_raddr;
  logic                  ang_we;
  logic [NODE_W-1:0]     ang_waddr, ang_raddr;
  logic [ANGLE_BITS-1:0] ang_wdata, ang_rd;
  logic                  vis_we, vis_wdata, vis_rd;
  logic [NODE_W-1:0]     vis_waddr;

  logic [ANGLE_BITS-1:0] diff, arc_d, cand_d;
  logic                  take;

  // counts above the store size scan the whole store
  assign n_eff = (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;

  assign sweeping  = cmd_i.sweep_all | cmd_i.sweep_vis;
  assign clr_cnt_d = sweeping ? clr_cnt_q + LINK_AW'(1) : '0;
  assign scan_go   = cmd_i.scan_issue && (scan_q < n_eff);

  // link store
  assign link_we    = cmd_i.sweep_all | cmd_i.wr_link_ab | cmd_i.wr_link_ba;
  assign link_waddr = cmd_i.sweep_all  ? clr_cnt_q :
                      cmd_i.wr_link_ab ? {a_q, b_q} : {b_q, a_q};
  assign link_wdata = cmd_i.sweep_all ? 1'b0 : present_q;
  assign link_raddr = {cur_q, scan_q[NODE_W-1:0]};

  ggr_ram #(.WIDTH(1), .DEPTH(LINK_DEPTH)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rd)
  );

  // angle store; cleared alongside the link sweep
  assign ang_we    = cmd_i.sweep_all | cmd_i.wr_angle;
  assign ang_waddr = cmd_i.sweep_all ? clr_cnt_q[NODE_W-1:0] : a_q;
  assign ang_wdata = cmd_i.sweep_all ? '0 : ang_q;
  assign ang_raddr = cmd_i.route_init ? b_q : scan_q[NODE_W-1:0];

  ggr_ram #(.WIDTH(ANGLE_BITS), .DEPTH(MAX_NODES)) u_angle_ram (
    .clk_i   (clk_i),
    .we_i    (ang_we),
    .waddr_i (ang_waddr),
    .wdata_i (ang_wdata),
    .raddr_i (ang_raddr),
    .rdata_o (ang_rd)
  );

  // visited marks
  assign vis_we    = sweeping | cmd_i.route_init | cmd_i.visit_write;
  assign vis_waddr = sweeping ? clr_cnt_q[NODE_W-1:0] :
                     cmd_i.route_init ? a_q : best_q;
  assign vis_wdata = !sweeping;

  ggr_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visited_ram (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .raddr_i (best_q),
    .rdata_o (vis_rd)
  );

  // circular distance: the wrapped difference folded onto the short arc
  assign diff   = tgt_ang_q - ang_rd;
  assign arc_d  = diff[ANGLE_BITS-1] ? (~diff + ANGLE_BITS'(1)) : diff;
  assign cand_d = (pend_idx_q == b_q) ? '0 : arc_d;
  assign take   = pend_q && link_rd && (!found_q || (cand_d < best_d_q));

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      cmd_q     <= in_command_i;
      a_q       <= in_node_a_i;
      b_q       <= in_node_b_i;
      ang_q     <= in_angle_i;
      present_q <= in_edge_present_i;
    end
    if (cmd_i.route_init) begin
      cur_q  <= a_q;
      hops_q <= '0;
    end else if (cmd_i.visit_write) begin
      cur_q  <= best_q;
      hops_q <= hops_q + HOP_W'(1);
    end
    if (cmd_i.tgt_latch) begin
      tgt_ang_q <= ang_rd;
    end
    if (scan_go) begin
      pend_idx_q <= scan_q[NODE_W-1:0];
    end
    if (take) begin
      best_q   <= pend_idx_q;
      best_d_q <= cand_d;
    end
    if (in_accept_i) begin
      res_q <= ST_OK;
    end else if (cmd_i.set_res) begin
      res_q <= cmd_i.res_code;
    end
    if (cmd_i.res_load) begin
      out_status_q <= res_q;
      out_hop_q    <= (res_q == ST_REACHED) ? hops_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RESET;
      clr_cnt_q    <= '0;
      scan_q       <= '0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_node_count_i;
      end
      clr_cnt_q <= clr_cnt_d;
      if (cmd_i.scan_start) begin
        scan_q  <= '0;
        found_q <= 1'b0;
        pend_q  <= 1'b0;
      end else begin
        pend_q <= scan_go;
        if (scan_go) begin
          scan_q <= scan_q + CNT_W'(1);
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.cmd            = cmd_q;
    sts_o.sweep_all_last = &clr_cnt_q;
    sts_o.sweep_vis_last = &clr_cnt_q[NODE_W-1:0];
    sts_o.at_target      = (cur_q == b_q);
    sts_o.scan_done      = !pend_q && (scan_q >= n_eff);
    sts_o.found          = found_q;
    sts_o.visited_hit    = vis_rd;
    sts_o.out_free       = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_hop_count_o = out_hop_q;

  a_pend_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ({1'b0, pend_idx_q} < n_eff))
    else $error("scan compare beyond node count");

  a_first_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(found_q) |-> (best_q == $past(pend_idx_q)))
    else $error("first neighbor not taken as best");

  a_hops_only_on_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != ST_REACHED)) |-> (out_hop_q == '0))
    else $error("hop count set on a non-reached result");

endmodule

// ----- hdl/greedy_geometric_router.sv -----
// ----------------------------------------------------------------------------
// greedy_geometric_router
// Greedy routing over a node graph with positions on a circle: loads node
// angles and symmetric links, answers route queries with hops or failure.
//
//   channel   dir   word
//   item_i    in    command, node_a, node_b, angle, edge_present
//   result_o  out   status, hop_count
//   cfg_i     in    node_count
//
// After reset the link, angle and visited stores are cleared by a sweep
// through the link RAM; no item is taken meanwhile, cfg writes are.
// An edge write stores the link in both directions, a to b and then b to a.
// Route: the visited marks are cleared first, then each hop reads one link RAM
// entry per candidate, followed by the compare pipeline and the visited check.
// One item is in work at a time; a waiting result does not block accept,
// but the next result holds until the previous one is taken.
// ----------------------------------------------------------------------------
module greedy_geometric_router (
  input logic           clk_i,
  input logic           rst_ni,
  ggr_item_if.sink      item_i,
  ggr_result_if.source  result_o,
  ggr_cfg_if.sink       cfg_i
);
  import ggr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       in_ready;
  logic       in_accept;

  assign item_i.ready = in_ready;
  assign in_accept    = item_i.valid && in_ready;
  assign cfg_i.ready  = 1'b1;

  ggr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready)
  );

  ggr_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_accept_i       (in_accept),
    .in_command_i      (item_i.command),
    .in_node_a_i       (item_i.node_a),
    .in_node_b_i       (item_i.node_b),
    .in_angle_i        (item_i.angle),
    .in_edge_present_i (item_i.edge_present),
    .cfg_we_i          (cfg_i.valid),
    .cfg_node_count_i  (cfg_i.node_count),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (result_o.valid),
    .out_ready_i       (result_o.ready),
    .out_status_o      (result_o.status),
    .out_hop_count_o   (result_o.hop_count)
  );

endmodule
